// ===== hdl/bb2_pkg.sv =====
// ----------------------------------------------------------------------------
// Box blur 2x2 package
// Shared types and constants of the 2x2 box blur: payloads, register map and
// default sizes.
// ----------------------------------------------------------------------------
package bb2_pkg;

  localparam int CHAN_W     = 8;
  localparam int NUM_CHAN   = 4;
  localparam int PIX_W      = CHAN_W * NUM_CHAN;
  localparam int POS_W      = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;
  localparam int CNT_CFG_W  = 3;

  localparam int MAX_WIDTH_DEF  = 2048;
  localparam int MAX_HEIGHT_DEF = 2048;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 2'd2;

  localparam logic [CFG_DATA_W-1:0] WIDTH_RST  = 12'd640;
  localparam logic [CFG_DATA_W-1:0] HEIGHT_RST = 12'd480;
  localparam logic [CNT_CFG_W-1:0]  CHANS_RST  = 3'd3;

  typedef struct packed {
    logic [CHAN_W-1:0] chan0;
    logic [CHAN_W-1:0] chan1;
    logic [CHAN_W-1:0] chan2;
    logic [CHAN_W-1:0] chan3;
  } pix_in_t;

  typedef struct packed {
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
    logic [CHAN_W-1:0] out0;
    logic [CHAN_W-1:0] out1;
    logic [CHAN_W-1:0] out2;
    logic [CHAN_W-1:0] out3;
    logic              was_filtered;
    logic              run_end;
  } pix_out_t;

endpackage

// ===== hdl/bb2_in_if.sv =====
// ----------------------------------------------------------------------------
// Box blur 2x2 input channel
// Valid/ready channel that carries one incoming pixel per transfer.
// ----------------------------------------------------------------------------
interface bb2_in_if;
  logic             valid;
  logic             ready;
  bb2_pkg::pix_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/bb2_out_if.sv =====
// ----------------------------------------------------------------------------
// Box blur 2x2 result channel
// Valid/ready channel that carries one result pixel with its position.
// ----------------------------------------------------------------------------
interface bb2_out_if;
  logic              valid;
  logic              ready;
  bb2_pkg::pix_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/bb2_line_buf.sv =====
// ----------------------------------------------------------------------------
// Box blur 2x2 line buffer
// Single-port memory holding the previous row; read-first with registered
// read data, so one access returns the old entry and stores the new pixel.
// ----------------------------------------------------------------------------
module bb2_line_buf #(
  parameter int DEPTH = bb2_pkg::MAX_WIDTH_DEF,
  parameter int DW    = bb2_pkg::PIX_W
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [DW-1:0]            wdata,
  output logic [DW-1:0]            rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      rdata_r    <= mem[addr];
      mem[addr]  <= wdata;
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/box_blur_2x2_top.sv =====
// ----------------------------------------------------------------------------
// Box blur 2x2 top level
// Streaming 2x2 box filter over a raster pixel stream with a one-row line
// buffer. Results carry their coordinates and leave out of raster order.
//
//   Channel  Direction  Payload                                   Handshake
//   in_ch    in         chan0..chan3                              valid/ready
//   out_ch   out        pos_x, pos_y, out0..out3, was_filtered,   valid/ready
//                       run_end
//   cfg_*    in         cfg_index, cfg_data                       cfg_we only
//
// A pixel is taken in every cycle as long as each pixel yields at most one
// result and the output is not stalled; a pixel that yields two results
// (averaged neighbor and own edge pixel) holds the window stage until both
// are loaded into the single output register. Reset is synchronous and
// clears the position, the neighbor pixels and the valid and phase flags;
// the window and output data and the line buffer are not cleared. A stalled
// output backs up into the window stage, which then drops in_ch.ready.
// ----------------------------------------------------------------------------
module box_blur_2x2_top #(
  parameter int MAX_WIDTH  = bb2_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = bb2_pkg::MAX_HEIGHT_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  bb2_in_if.sink                          in_ch,
  bb2_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [bb2_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bb2_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int WW = (CW + 1 > bb2_pkg::CFG_DATA_W) ? CW + 1 : bb2_pkg::CFG_DATA_W;
  localparam int HW = (RW + 1 > bb2_pkg::CFG_DATA_W) ? RW + 1 : bb2_pkg::CFG_DATA_W;
  localparam int CHW = bb2_pkg::CHAN_W;
  localparam int PW  = bb2_pkg::PIX_W;

  typedef struct packed {
    logic [PW-1:0] pix;
    logic [PW-1:0] left;
    logic [CW-1:0] x;
    logic [RW-1:0] y;
    logic          filt;
    logic          at_edge;
  } win_t;

  logic [bb2_pkg::CFG_DATA_W-1:0] width_r, height_r;
  logic [bb2_pkg::CNT_CFG_W-1:0]  chans_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= bb2_pkg::WIDTH_RST;
      height_r <= bb2_pkg::HEIGHT_RST;
      chans_r  <= bb2_pkg::CHANS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        bb2_pkg::CFG_IMAGE_WIDTH:   width_r  <= cfg_data;
        bb2_pkg::CFG_IMAGE_HEIGHT:  height_r <= cfg_data;
        bb2_pkg::CFG_CHANNEL_COUNT: chans_r  <= cfg_data[bb2_pkg::CNT_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  logic [WW-1:0] w_ext, w;
  logic [HW-1:0] h_ext, h;
  logic [bb2_pkg::CNT_CFG_W-1:0] nch;

  always_comb begin
    w_ext = WW'(width_r);
    h_ext = HW'(height_r);
    if (w_ext == '0) w = WW'(1);
    else if (w_ext > WW'(MAX_WIDTH)) w = WW'(MAX_WIDTH);
    else w = w_ext;
    if (h_ext == '0) h = HW'(1);
    else if (h_ext > HW'(MAX_HEIGHT)) h = HW'(MAX_HEIGHT);
    else h = h_ext;
    if (chans_r == '0) nch = bb2_pkg::CNT_CFG_W'(1);
    else if (chans_r > bb2_pkg::CNT_CFG_W'(bb2_pkg::NUM_CHAN))
      nch = bb2_pkg::CNT_CFG_W'(bb2_pkg::NUM_CHAN);
    else nch = chans_r;
  end

  logic [CW-1:0] col_r, col_nxt, c;
  logic [RW-1:0] row_r, row_nxt, r;
  logic [HW-1:0] r0, r_inc;
  logic [WW-1:0] c_inc;
  logic          pos_wrap, col_wrap;
  logic [PW-1:0] pix;
  logic [CHW-1:0] in_bytes [bb2_pkg::NUM_CHAN];

  always_comb begin
    pos_wrap = WW'(col_r) >= w;
    c        = pos_wrap ? '0 : col_r;
    r0       = HW'(row_r) + HW'(pos_wrap);
    r        = (r0 >= h) ? '0 : r0[RW-1:0];
    c_inc    = WW'(c) + WW'(1);
    col_wrap = c_inc >= w;
    r_inc    = HW'(r) + HW'(1);
    col_nxt  = col_wrap ? '0 : c_inc[CW-1:0];
    if (col_wrap) row_nxt = (r_inc >= h) ? '0 : r_inc[RW-1:0];
    else row_nxt = r;

    in_bytes[0] = in_ch.data.chan0;
    in_bytes[1] = in_ch.data.chan1;
    in_bytes[2] = in_ch.data.chan2;
    in_bytes[3] = in_ch.data.chan3;
    for (int k = 0; k < bb2_pkg::NUM_CHAN; k++) begin
      pix[k*CHW +: CHW] = (bb2_pkg::CNT_CFG_W'(k) < nch) ? in_bytes[k] : '0;
    end
  end

  logic          s1_valid_r, ph_r, out_valid_r;
  win_t          s1_r;
  logic [PW-1:0] left_r, al_r, above;
  logic          in_acc, has_res, first_sel, last, out_free, load, s1_adv;
  bb2_pkg::pix_out_t out_r, res;
  logic [PW-1:0] mean, sel_pix;
  logic [CHW+1:0] sum;

  assign in_acc = in_ch.valid && in_ch.ready;

  bb2_line_buf #(
    .DEPTH (MAX_WIDTH),
    .DW    (PW)
  ) u_line_buf (
    .clk   (clk),
    .en    (in_acc),
    .addr  (c),
    .wdata (pix),
    .rdata (above)
  );

  always_comb begin
    for (int k = 0; k < bb2_pkg::NUM_CHAN; k++) begin
      sum = (CHW+2)'(al_r[k*CHW +: CHW]) + (CHW+2)'(above[k*CHW +: CHW])
          + (CHW+2)'(s1_r.left[k*CHW +: CHW]) + (CHW+2)'(s1_r.pix[k*CHW +: CHW]);
      mean[k*CHW +: CHW] = sum[CHW+1:2];
    end

    has_res   = s1_r.filt || s1_r.at_edge;
    first_sel = s1_r.filt && !ph_r;
    last      = !(first_sel && s1_r.at_edge);
    out_free  = !out_valid_r || out_ch.ready;
    load      = s1_valid_r && has_res && out_free;
    s1_adv    = s1_valid_r && (!has_res || (load && last));

    sel_pix          = first_sel ? mean : s1_r.pix;
    res.pos_x        = first_sel ? bb2_pkg::POS_W'(s1_r.x - CW'(1))
                                 : bb2_pkg::POS_W'(s1_r.x);
    res.pos_y        = first_sel ? bb2_pkg::POS_W'(s1_r.y - RW'(1))
                                 : bb2_pkg::POS_W'(s1_r.y);
    res.out0         = sel_pix[0*CHW +: CHW];
    res.out1         = sel_pix[1*CHW +: CHW];
    res.out2         = sel_pix[2*CHW +: CHW];
    res.out3         = sel_pix[3*CHW +: CHW];
    res.was_filtered = first_sel;
    res.run_end      = last;
  end

  assign in_ch.ready  = !s1_valid_r || s1_adv;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      left_r      <= '0;
      al_r        <= '0;
      s1_valid_r  <= 1'b0;
      ph_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        col_r  <= col_nxt;
        row_r  <= row_nxt;
        left_r <= pix;
      end
      if (s1_adv) al_r <= above;
      if (in_acc) s1_valid_r <= 1'b1;
      else if (s1_adv) s1_valid_r <= 1'b0;
      if (load && !last) ph_r <= 1'b1;
      else if (s1_adv) ph_r <= 1'b0;
      if (load) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_r.pix     <= pix;
      s1_r.left    <= left_r;
      s1_r.x       <= c;
      s1_r.y       <= r;
      s1_r.filt    <= (c != '0) && (r != '0);
      s1_r.at_edge <= (WW'(c) == w - WW'(1)) || (HW'(r) == h - HW'(1));
    end
    if (load) out_r <= res;
  end

  a_phase_only_for_two: assert property (@(posedge clk) disable iff (!rst_n)
    ph_r |-> (s1_valid_r && s1_r.filt && s1_r.at_edge))
    else $error("second-result phase set without a two-result pixel");

  a_window_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |=> (s1_valid_r && $stable(s1_r) && $stable(above)))
    else $error("window stage changed while stalled");

  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> s1_valid_r)
    else $error("accepted pixel did not reach the window stage");

  a_edge_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.was_filtered) |-> out_r.run_end)
    else $error("pass-through result not marked as last of its pixel");

  a_first_then_second: assert property (@(posedge clk) disable iff (!rst_n)
    (load && !last) |=> (ph_r && s1_valid_r))
    else $error("two-result pixel left before its second result");

endmodule
